// File: rtl/path_point_store_search_macros.svh
// Assertion macros for the path point store.
`ifndef PATH_POINT_STORE_SEARCH_MACROS_SVH
`define PATH_POINT_STORE_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPSS_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |-> (consequent)) else $error("%m: check failed");
`define PPSS_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |=> (consequent)) else $error("%m: check failed");
`else
`define PPSS_ASSERT_IMPL(label, clk, rst_n, antecedent, consequent)
`define PPSS_ASSERT_NEXT(label, clk, rst_n, antecedent, consequent)
`endif
`endif

// File: rtl/ppss_pkg.sv
// ----------------------------------------------------------------------------
// ppss_pkg
// Types and constants shared by the path point store modules.
// ----------------------------------------------------------------------------
package ppss_pkg;
    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int PT_W       = 32 + 32 + 32 + 16 + 16;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_BY_S    = 2'd2,
        ACT_NEAREST = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BEYOND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_STATUS  = 2'd1,
        OP_BY_S    = 2'd2,
        OP_NEAREST = 2'd3
    } t_op;

    // Classified command passed from front to back
    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [CNT_W-1:0]  count;
        logic              first;
        logic [31:0]       s;
        logic [31:0]       x;
        logic [31:0]       y;
        logic [15:0]       hd;
        logic [15:0]       kp;
    } t_cmd;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_READ  = 3'd1,
        BK_CALC  = 3'd2,
        BK_EVAL  = 3'd3,
        BK_FETCH = 3'd4,
        BK_EMIT  = 3'd5
    } t_bk_state;
endpackage

// File: rtl/ppss_ram.sv
// ----------------------------------------------------------------------------
// ppss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ppss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/ppss_front.sv
// ----------------------------------------------------------------------------
// ppss_front
// Accepts commands, tracks the point count and classifies each command.
// ----------------------------------------------------------------------------
module ppss_front
    import ppss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_position_s,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [15:0] i_heading,
    input  logic [15:0] i_curvature,
    input  logic [15:0] i_epsilon_s,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cmd             w_cmd;

    assign o_push = i_start && !i_full;

    always_comb begin
        w_cmd        = '0;
        w_cmd.s      = i_position_s;
        w_cmd.x      = i_coord_x;
        w_cmd.y      = i_coord_y;
        w_cmd.hd     = i_heading;
        w_cmd.kp     = i_curvature;
        w_cmd.count  = r_count;
        w_cmd.op     = OP_STATUS;
        w_cmd.status = ST_OK;
        n_count      = r_count;
        case (t_action'(i_action))
            ACT_APPEND: begin
                if (r_count == CNT_W'(MAX_POINTS)) begin
                    w_cmd.status = ST_FULL;
                end else begin
                    w_cmd.op = OP_APPEND;
                    n_count  = r_count + 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            ACT_BY_S: begin
                if (r_count == '0) begin
                    w_cmd.status = ST_EMPTY;
                end else begin
                    w_cmd.op    = OP_BY_S;
                    w_cmd.first = (i_position_s < {16'd0, i_epsilon_s});
                end
            end
            ACT_NEAREST: begin
                if (r_count == '0) begin
                    w_cmd.status = ST_EMPTY;
                end else begin
                    w_cmd.op = OP_NEAREST;
                end
            end
            default: ;
        endcase
    end

    assign o_cmd = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end
endmodule

// File: rtl/ppss_queue.sv
// ----------------------------------------------------------------------------
// ppss_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module ppss_queue
    import ppss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_data [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

// File: rtl/ppss_back.sv
// ----------------------------------------------------------------------------
// ppss_back
// Executes commands against the point memory: append, scan by arc length,
// and nearest-point scan with one squared distance per stored point.
// ----------------------------------------------------------------------------
module ppss_back
    import ppss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_done,
    output logic [7:0]  o_point_index,
    output logic [31:0] o_point_s,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [15:0] o_point_heading,
    output logic [15:0] o_point_curvature,
    output logic [1:0]  o_status
);
    t_bk_state        r_state, n_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_best;
    logic [CNT_W-1:0] r_left;
    logic             r_have;
    logic [64:0]      r_best_d;
    logic [63:0]      r_sx, r_sy;
    logic             r_out_v;
    logic [7:0]       r_o_idx;
    logic [31:0]      r_o_s, r_o_x, r_o_y;
    logic [15:0]      r_o_hd, r_o_kp;
    logic [1:0]       r_o_st;

    logic             w_we;
    logic [IDX_W-1:0] w_raddr;
    logic [PT_W-1:0]  w_rdata;
    logic [31:0]      m_s, m_x, m_y;
    logic [15:0]      m_hd, m_kp;
    logic [32:0]      w_ddx, w_ddy;
    logic [32:0]      w_adx, w_ady;
    logic [64:0]      w_d;
    logic             w_last;

    assign {m_s, m_x, m_y, m_hd, m_kp} = w_rdata;
    assign w_we   = (r_state == BK_IDLE) && i_valid && (i_cmd.op == OP_APPEND);
    assign w_last = (r_left == CNT_W'(1));

    ppss_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_cmd.count[IDX_W-1:0]),
        .i_wdata ({i_cmd.s, i_cmd.x, i_cmd.y, i_cmd.hd, i_cmd.kp}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ddx = {m_x[31], m_x} - {r_cmd.x[31], r_cmd.x};
    assign w_ddy = {m_y[31], m_y} - {r_cmd.y[31], r_cmd.y};
    assign w_adx = w_ddx[32] ? -w_ddx : w_ddx;
    assign w_ady = w_ddy[32] ? -w_ddy : w_ddy;
    assign w_d   = {1'b0, r_sx} + {1'b0, r_sy};

    // memory address: current scan index, zero while idle, best index in fetch
    always_comb begin
        w_raddr = r_idx;
        if (r_state == BK_IDLE) begin
            w_raddr = '0;
        end else if (r_state == BK_FETCH) begin
            w_raddr = r_best;
        end
    end

    assign o_pop = (r_state == BK_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.op)
                        OP_BY_S, OP_NEAREST: n_state = BK_READ;
                        default:             n_state = BK_IDLE;
                    endcase
                end
            end
            BK_READ: n_state = (r_cmd.op == OP_NEAREST) ? BK_CALC : BK_EVAL;
            BK_CALC: n_state = BK_EVAL;
            BK_EVAL: begin
                if (r_cmd.op == OP_BY_S) begin
                    if (r_cmd.first || m_s >= r_cmd.s || w_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_state = BK_READ;
                    end
                end else begin
                    n_state = w_last ? BK_FETCH : BK_READ;
                end
            end
            BK_FETCH: n_state = BK_EMIT;
            BK_EMIT:  n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= 1'b0;
            case (r_state)
                BK_IDLE: r_out_v <= i_valid && (i_cmd.op == OP_APPEND
                                                || i_cmd.op == OP_STATUS);
                BK_EVAL: r_out_v <= (r_cmd.op == OP_BY_S) && (n_state == BK_IDLE);
                BK_EMIT: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_cmd    <= i_cmd;
                r_idx    <= '0;
                r_best   <= '0;
                r_left   <= i_cmd.count;
                r_have   <= 1'b0;
                r_o_idx  <= '0;
                r_o_s    <= '0;
                r_o_x    <= '0;
                r_o_y    <= '0;
                r_o_hd   <= '0;
                r_o_kp   <= '0;
                r_o_st   <= i_cmd.status;
                if (i_cmd.op == OP_APPEND) begin
                    r_o_idx <= 8'(i_cmd.count[IDX_W-1:0]);
                    r_o_s   <= i_cmd.s;
                    r_o_x   <= i_cmd.x;
                    r_o_y   <= i_cmd.y;
                    r_o_hd  <= i_cmd.hd;
                    r_o_kp  <= i_cmd.kp;
                end
            end
            BK_READ: ;
            BK_CALC: begin
                // squares registered here; compared in the BK_EVAL state that follows
                r_sx <= 64'(w_adx) * 64'(w_adx);
                r_sy <= 64'(w_ady) * 64'(w_ady);
            end
            BK_EVAL: begin
                r_idx  <= r_idx + 1'b1;
                r_left <= r_left - 1'b1;
                if (r_cmd.op == OP_BY_S) begin
                    if (r_cmd.first || m_s >= r_cmd.s) begin
                        r_o_idx <= 8'(r_idx);
                        r_o_s   <= m_s;
                        r_o_x   <= m_x;
                        r_o_y   <= m_y;
                        r_o_hd  <= m_hd;
                        r_o_kp  <= m_kp;
                        r_o_st  <= ST_OK;
                    end else if (w_last) begin
                        r_o_st <= ST_BEYOND;
                    end
                end else begin
                    if (!r_have || w_d < r_best_d) begin
                        r_best_d <= w_d;
                        r_best   <= r_idx;
                        r_have   <= 1'b1;
                    end
                end
            end
            BK_EMIT: begin
                r_o_idx <= 8'(r_best);
                r_o_s   <= m_s;
                r_o_x   <= m_x;
                r_o_y   <= m_y;
                r_o_hd  <= m_hd;
                r_o_kp  <= m_kp;
                r_o_st  <= ST_OK;
            end
            default: ;
        endcase
    end

    assign o_done            = r_out_v;
    assign o_point_index     = r_o_idx;
    assign o_point_s         = r_o_s;
    assign o_point_x         = r_o_x;
    assign o_point_y         = r_o_y;
    assign o_point_heading   = r_o_hd;
    assign o_point_curvature = r_o_kp;
    assign o_status          = r_o_st;
endmodule

// File: rtl/path_point_store_search.sv
// Append, clear and error results are produced from the idle state; find by arc
// length reads the stored points in order up to the first match or the last point;
// find nearest reads all N points, with one memory read and one squared distance a point.
// The back end runs one command at a time; a two-entry queue takes commands
// ahead. Synchronous active-low reset empties the table, sets epsilon_s to 1.
// Results strobe one cycle, no stall.
`include "path_point_store_search_macros.svh"
// ----------------------------------------------------------------------------
// path_point_store_search
// Path point table with append, clear, arc length lookup and nearest search.
// ----------------------------------------------------------------------------
module path_point_store_search
    import ppss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_position_s,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [15:0] i_heading,
    input  logic [15:0] i_curvature,
    output logic        o_done,
    output logic [7:0]  o_point_index,
    output logic [31:0] o_point_s,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic [15:0] o_point_heading,
    output logic [15:0] o_point_curvature,
    output logic [1:0]  o_status
);
    logic [15:0] r_eps;
    logic        w_full, w_push, w_qv, w_pop;
    t_cmd        w_in_cmd, w_q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= 16'd1;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    assign busy = w_full;

    ppss_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_action(i_action),
        .i_position_s(i_position_s), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_heading(i_heading), .i_curvature(i_curvature), .i_epsilon_s(r_eps),
        .i_full(w_full), .o_push(w_push), .o_cmd(w_in_cmd)
    );

    ppss_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_in_cmd),
        .i_pop(w_pop), .o_full(w_full), .o_valid(w_qv), .o_cmd(w_q_cmd)
    );

    ppss_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_cmd(w_q_cmd),
        .o_pop(w_pop), .o_done(o_done), .o_point_index(o_point_index),
        .o_point_s(o_point_s), .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_heading(o_point_heading), .o_point_curvature(o_point_curvature),
        .o_status(o_status)
    );

    `PPSS_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, w_full, !w_push)
    `PPSS_ASSERT_IMPL(a_pop_needs_valid, i_clk, i_rst_n, w_pop, w_qv)
    `PPSS_ASSERT_NEXT(a_append_done, i_clk, i_rst_n, w_pop && w_q_cmd.op == OP_APPEND, o_done)
endmodule

// File: verif/path_point_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_point_checker
// Watches the command and result ports of the path point store, keeps its own
// copy of the point table, predicts one result per accepted command and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module path_point_checker
    import ppss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_position_s,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [15:0] i_heading,
    input  logic [15:0] i_curvature,
    input  logic        i_done,
    input  logic [7:0]  i_point_index,
    input  logic [31:0] i_point_s,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [15:0] i_point_heading,
    input  logic [15:0] i_point_curvature,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] s;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hd;
        logic [15:0] kp;
        t_status     st;
    } t_point_result;

    logic [31:0] arc_tab [MAX_POINTS];
    logic [31:0] x_tab   [MAX_POINTS];
    logic [31:0] y_tab   [MAX_POINTS];
    logic [15:0] hd_tab  [MAX_POINTS];
    logic [15:0] kp_tab  [MAX_POINTS];
    int          stored_points;
    logic [15:0] epsilon_s;
    t_point_result expected_points [$];

    function automatic t_point_result stored_point(input int i);
        t_point_result r;
        r.idx = i[7:0];
        r.s   = arc_tab[i];
        r.x   = x_tab[i];
        r.y   = y_tab[i];
        r.hd  = hd_tab[i];
        r.kp  = kp_tab[i];
        r.st  = ST_OK;
        return r;
    endfunction

    function automatic t_point_result status_only(input t_status st);
        t_point_result r;
        r    = '0;
        r.st = st;
        return r;
    endfunction

    // Apply one command to the table copy and return the result it causes.
    task automatic lookup_point(input t_action act, input logic [31:0] s,
                                input logic [31:0] x, input logic [31:0] y,
                                input logic [15:0] hd, input logic [15:0] kp,
                                output t_point_result r);
        logic signed [32:0] dx, dy;
        logic [32:0]        adx, ady;
        logic [66:0]        sq_dist, best_dist;
        int                 best;
        bit                 found;
        best      = 0;
        best_dist = '0;
        found     = 0;
        case (act)
            ACT_APPEND: begin
                if (stored_points >= MAX_POINTS) begin
                    r = status_only(ST_FULL);
                end else begin
                    arc_tab[stored_points] = s;
                    x_tab[stored_points]   = x;
                    y_tab[stored_points]   = y;
                    hd_tab[stored_points]  = hd;
                    kp_tab[stored_points]  = kp;
                    r = stored_point(stored_points);
                    stored_points++;
                end
            end
            ACT_CLEAR: begin
                stored_points = 0;
                r = status_only(ST_OK);
            end
            ACT_BY_S: begin
                if (stored_points == 0) begin
                    r = status_only(ST_EMPTY);
                end else if (s < {16'd0, epsilon_s}) begin
                    r = stored_point(0);
                end else begin
                    r = status_only(ST_BEYOND);
                    for (int i = 0; i < stored_points && !found; i++) begin
                        if (arc_tab[i] >= s) begin
                            r = stored_point(i);
                            found = 1;
                        end
                    end
                end
            end
            default: begin
                if (stored_points == 0) begin
                    r = status_only(ST_EMPTY);
                end else begin
                    for (int i = 0; i < stored_points; i++) begin
                        dx   = $signed({x_tab[i][31], x_tab[i]}) - $signed({x[31], x});
                        dy   = $signed({y_tab[i][31], y_tab[i]}) - $signed({y[31], y});
                        adx  = dx[32] ? -dx : dx;
                        ady  = dy[32] ? -dy : dy;
                        sq_dist = {34'd0, adx} * {34'd0, adx} + {34'd0, ady} * {34'd0, ady};
                        // strict compare keeps the lowest index on a tie
                        if (i == 0 || sq_dist < best_dist) begin
                            best      = i;
                            best_dist = sq_dist;
                        end
                    end
                    r = stored_point(best);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_point_result want, got;
        if (!i_rst_n) begin
            stored_points = 0;
            epsilon_s     = 16'd1;
            expected_points.delete();
        end else begin
            if (i_done) begin
                got = '{i_point_index, i_point_s, i_point_x, i_point_y,
                        i_point_heading, i_point_curvature, t_status'(i_status)};
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected transaction", {30'd0, i_status}, '0);
                end else begin
                    want = expected_points.pop_front();
                    if (got.idx != want.idx)
                        report_mismatch("point_index", 32'(got.idx), 32'(want.idx));
                    if (got.s != want.s)     report_mismatch("point_s", got.s, want.s);
                    if (got.x != want.x)     report_mismatch("point_x", got.x, want.x);
                    if (got.y != want.y)     report_mismatch("point_y", got.y, want.y);
                    if (got.hd != want.hd)
                        report_mismatch("point_heading", 32'(got.hd), 32'(want.hd));
                    if (got.kp != want.kp)
                        report_mismatch("point_curvature", 32'(got.kp), 32'(want.kp));
                    if (got.st != want.st)
                        report_mismatch("status", 32'(got.st), 32'(want.st));
                end
            end
            if (i_cfg_we) epsilon_s = i_cfg_data;
            if (i_start && !i_busy) begin
                lookup_point(t_action'(i_action), i_position_s, i_coord_x, i_coord_y,
                             i_heading, i_curvature, want);
                expected_points = {expected_points, want};
            end
        end
        o_pending = expected_points.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random append, clear and search commands into the path
// point store across several epsilon settings, with random gaps, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
    import ppss_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic [1:0]  i_action = '0;
    logic [31:0] i_position_s = '0;
    logic [31:0] i_coord_x = '0;
    logic [31:0] i_coord_y = '0;
    logic [15:0] i_heading = '0;
    logic [15:0] i_curvature = '0;
    logic        o_done;
    logic [7:0]  o_point_index;
    logic [31:0] o_point_s, o_point_x, o_point_y;
    logic [15:0] o_point_heading, o_point_curvature;
    logic [1:0]  o_status;
    int          fail_count, pending;

    // stimulus-side shadow of appended arc lengths, used to aim queries
    logic [31:0] arc_log [MAX_POINTS];
    int          appended;
    logic [31:0] last_s;
    int          issued;
    bit          quiet;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    path_point_store_search u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_data,
        .i_action, .i_position_s, .i_coord_x, .i_coord_y, .i_heading, .i_curvature,
        .o_done, .o_point_index, .o_point_s, .o_point_x, .o_point_y,
        .o_point_heading, .o_point_curvature, .o_status
    );

    path_point_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_data,
        .i_action, .i_position_s, .i_coord_x, .i_coord_y, .i_heading, .i_curvature,
        .i_done(o_done), .i_point_index(o_point_index), .i_point_s(o_point_s),
        .i_point_x(o_point_x), .i_point_y(o_point_y),
        .i_point_heading(o_point_heading), .i_point_curvature(o_point_curvature),
        .i_status(o_status), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold the command until accepted, then idle for a random gap.
    task automatic issue(input t_action act, input logic [31:0] s, input logic [31:0] x,
                         input logic [31:0] y, input logic [15:0] hd,
                         input logic [15:0] kp);
        int gap;
        start        <= 1'b1;
        i_action     <= act;
        i_position_s <= s;
        i_coord_x    <= x;
        i_coord_y    <= y;
        i_heading    <= hd;
        i_curvature  <= kp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
        if (act == ACT_APPEND && appended < MAX_POINTS) begin
            arc_log[appended] = s;
            appended++;
        end
        if (act == ACT_CLEAR) appended = 0;
        gap = gap_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_epsilon(input logic [15:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom();
        // small spread makes equal distances and ties likely
        return 32'($signed($urandom_range(0, 64)) - 32) <<< 12;
    endfunction

    function automatic logic [31:0] rand_query_s();
        int r;
        r = $urandom_range(0, 9);
        if (appended > 0 && r < 6)
            return arc_log[$urandom_range(0, appended - 1)] + $urandom_range(0, 2) - 1;
        if (r == 6) return '0;
        if (r == 7) return $urandom_range(0, 65535);
        if (r == 8) return last_s + $urandom_range(1, 1000);
        return $urandom();
    endfunction

    task automatic random_item(input int clear_pct);
        int          r;
        logic [31:0] s;
        r = $urandom_range(0, 99);
        if (r < clear_pct) begin
            issue(ACT_CLEAR, $urandom(), $urandom(), $urandom(), 16'($urandom()),
                  16'($urandom()));
            last_s = '0;
        end else if (r < 50) begin
            s = ($urandom_range(0, 9) == 0) ? $urandom() : last_s + $urandom_range(0, 262144);
            last_s = s;
            issue(ACT_APPEND, s, rand_coord(), rand_coord(), 16'($urandom()),
                  16'($urandom()));
        end else if (r < 75) begin
            issue(ACT_BY_S, rand_query_s(), $urandom(), $urandom(), 16'($urandom()),
                  16'($urandom()));
        end else begin
            issue(ACT_NEAREST, $urandom(), rand_coord(), rand_coord(), 16'($urandom()),
                  16'($urandom()));
        end
    endtask

    initial begin
        int phase;
        appended = 0;
        issued   = 0;
        last_s   = '0;
        quiet    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, extremes, unsorted arc lengths, ties, beyond last point
        issue(ACT_BY_S, 32'd5, '0, '0, '0, '0);
        issue(ACT_NEAREST, '0, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
        issue(ACT_APPEND, '0, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 16'h7fff);
        issue(ACT_APPEND, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 16'h8000);
        issue(ACT_BY_S, '0, '0, '0, '0, '0);
        issue(ACT_BY_S, 32'd1, '0, '0, '0, '0);
        issue(ACT_BY_S, 32'hffff_ffff, '0, '0, '0, '0);
        issue(ACT_NEAREST, '0, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
        issue(ACT_NEAREST, '0, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
        issue(ACT_NEAREST, '0, '0, '0, '0, '0);
        issue(ACT_CLEAR, '0, '0, '0, '0, '0);
        issue(ACT_NEAREST, '0, '0, '0, '0, '0);
        issue(ACT_APPEND, 32'd100, 32'd10, 32'd0, 16'd1, 16'd2);
        issue(ACT_APPEND, 32'd50, -32'sd10, 32'd0, 16'd3, 16'd4);
        issue(ACT_APPEND, 32'd300, 32'd0, 32'd10, 16'd5, 16'd6);
        issue(ACT_BY_S, 32'd60, '0, '0, '0, '0);
        issue(ACT_BY_S, 32'd200, '0, '0, '0, '0);
        issue(ACT_BY_S, 32'd301, '0, '0, '0, '0);
        issue(ACT_NEAREST, '0, '0, '0, '0, '0);
        write_epsilon(16'd0);
        issue(ACT_BY_S, '0, '0, '0, '0, '0);
        write_epsilon(16'hffff);
        issue(ACT_BY_S, 32'd400, '0, '0, '0, '0);
        issue(ACT_BY_S, 32'h0001_0000, '0, '0, '0, '0);
        issue(ACT_CLEAR, '0, '0, '0, '0, '0);
        last_s = '0;

        phase = 0;
        while (issued < 800) begin
            case (phase)
                0:       write_epsilon(16'd0);
                1:       write_epsilon(16'hffff);
                2:       write_epsilon(16'd1);
                default: write_epsilon(16'($urandom_range(0, 65535)));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                // fill to capacity, then push past it
                issue(ACT_CLEAR, '0, '0, '0, '0, '0);
                last_s = '0;
                while (appended < MAX_POINTS) begin
                    last_s = last_s + $urandom_range(0, 65536);
                    issue(ACT_APPEND, last_s, rand_coord(), rand_coord(), 16'($urandom()),
                          16'($urandom()));
                end
                repeat (12) random_item(0);
            end else begin
                repeat ($urandom_range(60, 100)) random_item(3);
            end
            phase++;
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
